// ----- hdl/hpe_pkg.sv -----
// Shared types, constants and arithmetic helpers for the hash table probe engine.
// Holds the microcode table of the sequencer. Depends on nothing.
package hpe_pkg;

  // Field widths of the request, response and configuration channels.
  localparam int unsigned OP_W     = 2;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned SIZE_W   = 11;

  // Lower table size limit and reset value.
  localparam int unsigned SIZE_MIN = 2;
  localparam int unsigned SIZE_RST = 263;

  // The remainder unit retires two dividend bits per cycle.
  localparam int unsigned DIV_STEPS = KEY_W / 2;
  localparam int unsigned DCNT_W    = $clog2(DIV_STEPS);

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_ERASE  = 2'd1,
    OP_FIND   = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_ERASED    = 3'd5
  } status_e;

  // Microprogram step addresses.
  typedef enum logic [2:0] {
    U_CLEAR = 3'd0,
    U_IDLE  = 3'd1,
    U_DIV   = 3'd2,
    U_ISSUE = 3'd3,
    U_EVAL  = 3'd4,
    U_EMIT  = 3'd5
  } upc_e;

  // Jump conditions tested by each step.
  typedef enum logic [2:0] {
    C_ALWAYS     = 3'd0,
    C_CLR_LAST   = 3'd1,
    C_IN_FIRE    = 3'd2,
    C_DIV_DONE   = 3'd3,
    C_PROBE_STOP = 3'd4,
    C_OUT_FREE   = 3'd5
  } cond_e;

  // One control word of the microprogram.
  typedef struct packed {
    logic  clr_en;    // write an empty entry at the clear counter
    logic  accept;    // request channel ready
    logic  div_run;   // remainder unit running, probe registers start over
    logic  issue;     // read the slot memory at the next probe position
    logic  eval;      // judge the slot just read, maybe write it back
    logic  emit;      // move the result into the response register
    cond_e cond;
    upc_e  on_true;
    upc_e  on_false;
  } ctrl_word_t;

  // Reduce a value known to be below 2*n into the range [0, n).
  function automatic logic [SIZE_W-1:0] reduce_once(input logic [SIZE_W:0]   r,
                                                    input logic [SIZE_W-1:0] n);
    logic [SIZE_W:0] n_ext;
    n_ext = {1'b0, n};
    if (r >= n_ext) begin
      reduce_once = SIZE_W'(r - n_ext);
    end else begin
      reduce_once = SIZE_W'(r);
    end
  endfunction

  // Sum of two residues modulo n.
  function automatic logic [SIZE_W-1:0] mod_add(input logic [SIZE_W-1:0] a,
                                                input logic [SIZE_W-1:0] b,
                                                input logic [SIZE_W-1:0] n);
    mod_add = reduce_once({1'b0, a} + {1'b0, b}, n);
  endfunction

  // Microprogram read-only table.
  function automatic ctrl_word_t ucode(input upc_e pc);
    ctrl_word_t w;
    w = '{clr_en: 1'b0, accept: 1'b0, div_run: 1'b0, issue: 1'b0, eval: 1'b0,
          emit: 1'b0, cond: C_ALWAYS, on_true: U_IDLE, on_false: U_IDLE};
    unique case (pc)
      U_CLEAR: begin
        w.clr_en   = 1'b1;
        w.cond     = C_CLR_LAST;
        w.on_true  = U_IDLE;
        w.on_false = U_CLEAR;
      end
      U_IDLE: begin
        w.accept   = 1'b1;
        w.cond     = C_IN_FIRE;
        w.on_true  = U_DIV;
        w.on_false = U_IDLE;
      end
      U_DIV: begin
        w.div_run  = 1'b1;
        w.cond     = C_DIV_DONE;
        w.on_true  = U_ISSUE;
        w.on_false = U_DIV;
      end
      U_ISSUE: begin
        w.issue    = 1'b1;
        w.cond     = C_ALWAYS;
        w.on_true  = U_EVAL;
        w.on_false = U_EVAL;
      end
      U_EVAL: begin
        w.eval     = 1'b1;
        w.cond     = C_PROBE_STOP;
        w.on_true  = U_EMIT;
        w.on_false = U_ISSUE;
      end
      U_EMIT: begin
        w.emit     = 1'b1;
        w.cond     = C_OUT_FREE;
        w.on_true  = U_IDLE;
        w.on_false = U_EMIT;
      end
      default: begin
        w.cond     = C_ALWAYS;
        w.on_true  = U_IDLE;
        w.on_false = U_IDLE;
      end
    endcase
    ucode = w;
  endfunction

endpackage

// ----- hdl/hpe_if.sv -----
// Channel interfaces of the hash table probe engine: request, response, configuration.
// Depends on hpe_pkg for the field widths.
interface hpe_req_if;
  import hpe_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [KEY_W-1:0]  key;
  logic [VAL_W-1:0]  value;
  modport source (output valid, output operation, output key, output value, input ready);
  modport sink   (input valid, input operation, input key, input value, output ready);
endinterface

interface hpe_rsp_if;
  import hpe_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [VAL_W-1:0]    value_out;
  logic [SIZE_W-1:0]   slot;
  modport source (output valid, output status, output value_out, output slot, input ready);
  modport sink   (input valid, input status, input value_out, input slot, output ready);
endinterface

interface hpe_cfg_if;
  import hpe_pkg::*;
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] table_size;
  modport source (output valid, output table_size, input ready);
  modport sink   (input valid, input table_size, output ready);
endinterface

// ----- hdl/hpe_urem.sv -----
// Iterative remainder unit: 32-bit key modulo the table size, two bits per cycle.
// Depends on hpe_pkg for widths and the conditional-subtract helper.
module hpe_urem (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [hpe_pkg::KEY_W-1:0]  dividend_i,
  input  logic [hpe_pkg::SIZE_W-1:0] divisor_i,
  output logic                      busy_o,
  output logic [hpe_pkg::SIZE_W-1:0] rem_o
);
  import hpe_pkg::*;

  logic              busy_q;
  logic [DCNT_W-1:0] cnt_q;
  logic [KEY_W-1:0]  quo_q;
  logic [SIZE_W-1:0] rem_q;
  logic [SIZE_W-1:0] rem_one;
  logic [SIZE_W-1:0] rem_two;

  // Two restoring steps: shift in a dividend bit, subtract the divisor if it fits.
  always_comb begin
    rem_one = reduce_once({rem_q, quo_q[KEY_W-1]}, divisor_i);
    rem_two = reduce_once({rem_one, quo_q[KEY_W-2]}, divisor_i);
  end

  // Step counter and busy flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + DCNT_W'(1);
      if (cnt_q == DCNT_W'(DIV_STEPS - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Dividend shift register and partial remainder.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= quo_q << 2;
      rem_q <= rem_two;
    end
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

// ----- hdl/hash_table_probe_engine.sv -----
// Hash table probe engine: open-addressed key/value table; the probe offsets are running
// sums of squares. A request makes 1 to PROBE_COUNT probes after the key remainder unit,
// each a slot memory read and its evaluation. One request at a time; the next can be
// taken from the cycle after the result enters the response register. After reset a
// clearing pass writes an empty entry to each of the MAX_SLOTS slots (1031 by default)
// before the first request is taken.
module hash_table_probe_engine #(
  parameter int unsigned MAX_SLOTS   = 1031,
  parameter int unsigned PROBE_COUNT = 14
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  hpe_req_if.sink   req_i,
  hpe_rsp_if.source rsp_o,
  hpe_cfg_if.sink   cfg_i
);
  import hpe_pkg::*;

  localparam int unsigned IDX_W    = $clog2(MAX_SLOTS);
  localparam int unsigned PCNT_W   = (PROBE_COUNT > 1) ? $clog2(PROBE_COUNT) : 1;
  localparam int unsigned SIZE_MAX = (MAX_SLOTS < 2047) ? MAX_SLOTS : 2047;

  typedef struct packed {
    logic             used;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] payload;
  } entry_t;

  typedef struct packed {
    status_e           status;
    logic [VAL_W-1:0]  value_out;
    logic [SIZE_W-1:0] slot;
  } result_t;

  // Sequencer.
  upc_e       upc_q, upc_d;
  ctrl_word_t cw;
  logic       cond_true;

  // Datapath registers.
  logic [SIZE_W-1:0] size_q;
  logic [SIZE_W-1:0] size_in;
  logic [IDX_W-1:0]  clr_q;
  logic [OP_W-1:0]   op_q;
  logic [KEY_W-1:0]  key_q;
  logic [VAL_W-1:0]  val_q;
  logic [SIZE_W-1:0] pos_q, pos_d;
  logic [SIZE_W-1:0] sq_q, sq_d;
  logic [SIZE_W-1:0] dlt_q, dlt_d;
  logic [PCNT_W-1:0] probe_cnt_q;
  result_t           res_q, res_d;
  logic              rsp_valid_q;
  result_t           rsp_q;

  // Slot memory.
  entry_t            slot_mem_q [MAX_SLOTS];
  entry_t            rd_q;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  entry_t            mem_wdata;
  logic              eval_we;
  entry_t            eval_wdata;

  // Probe decision.
  logic req_fire;
  logic out_free;
  logic last_probe;
  logic key_hit;
  logic probe_stop;

  logic              div_busy;
  logic [SIZE_W-1:0] div_rem;

  hpe_urem u_urem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (req_fire),
    .dividend_i (req_i.key),
    .divisor_i  (size_q),
    .busy_o     (div_busy),
    .rem_o      (div_rem)
  );

  // Control word of the current step.
  assign cw = ucode(upc_q);

  assign req_fire = req_i.valid && req_i.ready;
  assign out_free = !rsp_valid_q || rsp_o.ready;

  // Jump condition select.
  always_comb begin
    unique case (cw.cond)
      C_ALWAYS:     cond_true = 1'b1;
      C_CLR_LAST:   cond_true = (clr_q == IDX_W'(MAX_SLOTS - 1));
      C_IN_FIRE:    cond_true = req_fire;
      C_DIV_DONE:   cond_true = !div_busy;
      C_PROBE_STOP: cond_true = probe_stop;
      C_OUT_FREE:   cond_true = out_free;
      default:      cond_true = 1'b1;
    endcase
  end

  // Next step address.
  always_comb begin
    upc_d = cond_true ? cw.on_true : cw.on_false;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= U_CLEAR;
    end else begin
      upc_q <= upc_d;
    end
  end

  // Configuration: the size is clamped to the supported range when written.
  always_comb begin
    if (cfg_i.table_size < SIZE_W'(SIZE_MIN)) begin
      size_in = SIZE_W'(SIZE_MIN);
    end else if (cfg_i.table_size > SIZE_W'(SIZE_MAX)) begin
      size_in = SIZE_W'(SIZE_MAX);
    end else begin
      size_in = cfg_i.table_size;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_W'(SIZE_RST);
    end else if (cfg_i.valid && cfg_i.ready) begin
      size_q <= size_in;
    end
  end

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = cw.accept;

  // Clearing pass counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cw.clr_en) begin
      clr_q <= clr_q + IDX_W'(1);
    end
  end

  // Request capture.
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      op_q  <= req_i.operation;
      key_q <= req_i.key;
      val_q <= req_i.value;
    end
  end

  // Modulo the size, the position adds the square and the square its odd increment.
  always_comb begin
    pos_d = mod_add(pos_q, sq_q, size_q);
    sq_d  = mod_add(sq_q, dlt_q, size_q);
    dlt_d = mod_add(dlt_q, SIZE_W'(2), size_q);
  end

  always_ff @(posedge clk_i) begin
    if (cw.div_run) begin
      pos_q <= div_rem;
      sq_q  <= '0;
      dlt_q <= SIZE_W'(1);
    end else if (cw.issue) begin
      pos_q <= pos_d;
      sq_q  <= sq_d;
      dlt_q <= dlt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_cnt_q <= '0;
    end else if (cw.div_run) begin
      probe_cnt_q <= '0;
    end else if (cw.eval) begin
      probe_cnt_q <= probe_cnt_q + PCNT_W'(1);
    end
  end

  // Evaluate the slot just read.
  assign last_probe = (probe_cnt_q == PCNT_W'(PROBE_COUNT - 1));
  assign key_hit    = rd_q.used && (rd_q.key == key_q);

  always_comb begin
    probe_stop = 1'b0;
    eval_we    = 1'b0;
    eval_wdata = rd_q;
    res_d      = '{status: ST_NOT_FOUND, value_out: '0, slot: '0};
    unique case (op_q)
      OP_INSERT: begin
        if (!rd_q.used) begin
          probe_stop = 1'b1;
          eval_we    = 1'b1;
          eval_wdata = '{used: 1'b1, key: key_q, payload: val_q};
          res_d      = '{status: ST_INSERTED, value_out: '0, slot: pos_q};
        end else if (rd_q.key == key_q) begin
          probe_stop   = 1'b1;
          res_d.status = ST_DUPLICATE;
        end else if (last_probe) begin
          probe_stop   = 1'b1;
          res_d.status = ST_FULL;
        end
      end
      OP_ERASE: begin
        if (key_hit) begin
          probe_stop      = 1'b1;
          eval_we         = 1'b1;
          eval_wdata.used = 1'b0;
          res_d = '{status: ST_ERASED, value_out: rd_q.payload, slot: pos_q};
        end else if (last_probe) begin
          probe_stop = 1'b1;
        end
      end
      OP_FIND: begin
        if (key_hit) begin
          probe_stop = 1'b1;
          res_d = '{status: ST_FOUND, value_out: rd_q.payload, slot: pos_q};
        end else if (last_probe) begin
          probe_stop = 1'b1;
        end
      end
      default: begin
        probe_stop = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cw.eval) begin
      res_q <= res_d;
    end
  end

  // Memory write port: clearing pass or a probe write-back.
  assign mem_we    = cw.clr_en || (cw.eval && eval_we);
  assign mem_waddr = cw.clr_en ? clr_q : IDX_W'(pos_q);
  assign mem_wdata = cw.clr_en ? entry_t'('0) : eval_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem_q[mem_waddr] <= mem_wdata;
    end
  end

  // Memory read port with registered data.
  always_ff @(posedge clk_i) begin
    if (cw.issue) begin
      rd_q <= slot_mem_q[IDX_W'(pos_d)];
    end
  end

  // Response register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (cw.emit && out_free) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cw.emit && out_free) begin
      rsp_q <= res_q;
    end
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.status    = rsp_q.status;
  assign rsp_o.value_out = rsp_q.value_out;
  assign rsp_o.slot      = rsp_q.slot;

  // No request is taken while the table is being cleared.
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == U_CLEAR) |-> !req_i.ready)
    else $error("request accepted during the clearing pass");

  // A find never modifies the table.
  a_find_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == U_EVAL && op_q == OP_FIND) |-> !mem_we)
    else $error("find wrote the slot memory");

  // Every probed position lies inside the table in use.
  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == U_EVAL) |-> (pos_q < size_q))
    else $error("probe position beyond table size");

  // Leaving the remainder step always starts the probe sequence.
  a_div_then_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == U_DIV && !div_busy) |=> (upc_q == U_ISSUE))
    else $error("sequencer skipped the first probe");

endmodule
